@@ rtl/plm_pkg.sv @@
// Shared types and constants for the polyline closest-point / lookahead block.
// No dependencies; imported by every module of the block except plm_ram.
package plm_pkg;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_FEW = 1'b1;

  localparam int XW    = 32;   // coordinate / speed width
  localparam int MW    = 33;   // multiplier operand width
  localparam int PW    = 66;   // product width
  localparam int DW    = 66;   // divisor and remainder width
  localparam int DVDW  = 96;   // dividend shift register width
  localparam int QW    = 42;   // kept quotient bits
  localparam int STW   = 7;    // divider step counter
  localparam int SQW   = 66;   // square root operand width
  localparam int RTW   = 33;   // square root result width
  localparam int LENW  = 40;   // path length width
  localparam int NUMW  = 41;   // position in index units, Q.30
  localparam int FRW   = 30;   // fraction bits of t and f
  localparam int CFGW  = 7;

  localparam logic [STW-1:0] T_STEPS    = 7'd30;
  localparam logic [STW-1:0] POS_STEPS  = 7'd57;
  localparam logic [STW-1:0] LOOK_STEPS = 7'd71;
  localparam logic [5:0]     SQ_STEPS   = 6'd33;
  localparam int             SQ_TOP     = 64;

  localparam logic [FRW:0]    ONE30   = 31'h4000_0000;
  localparam logic [LENW-1:0] LEN_MAX = {LENW{1'b1}};

  typedef struct packed {
    logic              req_type;
    logic [5:0]        wp_index;
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic signed [31:0] wp_speed;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic [30:0]       lookahead_dist;
  } plm_in_t;

  typedef struct packed {
    logic              status;
    logic signed [31:0] closest_x;
    logic signed [31:0] closest_y;
    logic [16:0]       path_pos;
    logic [32:0]       distance;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_speed;
  } plm_out_t;

  typedef struct packed {
    logic            start;
    logic [DW-1:0]   rem0;
    logic [DVDW-1:0] dvd;
    logic [DW-1:0]   divisor;
    logic [STW-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic           start;
    logic [SQW-1:0] op;
  } sq_req_t;

endpackage

@@ rtl/plm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/plm_mul.sv @@
// Shared unsigned multiplier with registered product.
// Depends on plm_pkg.
module plm_mul import plm_pkg::*; (
  input  logic          clk,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  output logic [PW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PW'(a) * PW'(b);
  end

endmodule

@@ rtl/plm_div.sv @@
// Restoring divider, one quotient bit per cycle, sticky overflow above QW bits.
// Depends on plm_pkg.
module plm_div import plm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  div_req_t      req,
  output logic          done,
  output logic [QW-1:0] quot,
  output logic          ovf
);

  logic            busy;
  logic [STW-1:0]  cnt;
  logic [DW-1:0]   rem;
  logic [DVDW-1:0] dvd;
  logic [DW-1:0]   dsr;
  logic [DW:0]     sh;
  logic [DW+1:0]   diff;
  logic            ge;

  assign sh   = {rem, dvd[DVDW-1]};
  assign diff = {1'b0, sh} - {2'b00, dsr};
  assign ge   = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= req.rem0;
        dvd  <= req.dvd;
        dsr  <= req.divisor;
        cnt  <= req.steps;
        quot <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        rem  <= ge ? diff[DW-1:0] : sh[DW-1:0];
        dvd  <= dvd << 1;
        quot <= {quot[QW-2:0], ge};
        ovf  <= ovf | quot[QW-1];
        cnt  <= cnt - STW'(1);
        if (cnt == STW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/plm_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle (floor).
// Depends on plm_pkg.
module plm_sqrt import plm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  sq_req_t        req,
  output logic           done,
  output logic [RTW-1:0] root
);

  logic           busy;
  logic [5:0]     cnt;
  logic [SQW-1:0] op;
  logic [SQW:0]   res;
  logic [SQW:0]   one;
  logic [SQW:0]   trial;
  logic           ge;

  assign trial = res + one;
  assign ge    = {1'b0, op} >= trial;
  assign root  = res[RTW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        res  <= '0;
        one  <= (SQW+1)'(1) << SQ_TOP;
        cnt  <= SQ_STEPS;
      end else if (busy) begin
        if (ge) begin
          op  <= op - trial[SQW-1:0];
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/polyline_closest_point_lookahead.sv @@
// Closest point and lookahead point on a stored polyline; depends on plm_pkg,
// plm_ram, plm_mul, plm_div, plm_sqrt.
// A load beat leaves the block ready. A query's time is set by the waypoint scan,
// plus a path length pass when the length is stale, and by the bit-serial divider
// (up to three divisions) and square-root unit.
// Reset (rst, synchronous): control idle, waypoint count and length cleared;
// waypoint table contents are not cleared.
module polyline_closest_point_lookahead import plm_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  plm_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output plm_out_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CFGW-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_RD, S_GET, S_SQX, S_SQY, S_SQS, S_SQRT, S_NEAR_CMP, S_SEG0,
    S_SEG_M1, S_SEG_M2, S_SEG_M3, S_SEG_M4, S_SEG_M5, S_SEG_T, S_SEG_T2,
    S_DIV_T, S_CX_M, S_CX_R, S_CY_R, S_DIST, S_POS, S_DIV_P, S_LOOK0,
    S_LOOK1, S_DIV_L, S_LOOK2, S_LOOK3, S_LX_M, S_LX_R, S_LY_R, S_LS_R, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_LEN, PH_NEAR, PH_SEGA, PH_SEGB, PH_DIST, PH_LOOKA, PH_LOOKB, PH_LAST
  } phase_t;

  function automatic logic [MW-1:0] mag33(logic [MW-1:0] v);
    return v[MW-1] ? (~v + MW'(1)) : v;
  endfunction

  function automatic logic [MW-1:0] diff33(logic [XW-1:0] a, logic [XW-1:0] b);
    return {a[XW-1], a} - {b[XW-1], b};
  endfunction

  // a + sign(d) * p / 2^30, product rounded half away from zero
  function automatic logic [XW-1:0] lerp_fin(logic [XW-1:0] a, logic [MW-1:0] d,
                                             logic [PW-1:0] p);
    logic [PW-1:0] pr;
    logic [XW+1:0] av;
    logic [XW+1:0] r;
    logic [XW+1:0] res;
    pr  = p + (PW'(1) << (FRW - 1));
    av  = {{2{a[XW-1]}}, a};
    r   = pr[FRW +: XW+2];
    res = d[MW-1] ? av - r : av + r;
    return res[XW-1:0];
  endfunction

  state_t state;
  phase_t phase;

  logic [CFGW-1:0] count_reg;
  logic            len_ok;
  logic [LENW-1:0] total_len;
  logic [CW-1:0]   n;
  logic [NUMW-1:0] end_v;
  logic            err;
  logic [XW-1:0]   qx, qy;
  logic [30:0]     la;
  logic [IW-1:0]   i, rd_idx, best_i, sa;
  logic [XW-1:0]   prev_x, prev_y;
  logic [MW-1:0]   dmx, dmy;
  logic [PW-1:0]   acc, best_d, len2;
  logic [XW-1:0]   ax, ay;
  logic [MW-1:0]   ex, ey, px, py;
  logic [PW:0]     pos, neg, dot;
  logic            dneg;
  logic [FRW:0]    t;
  logic [XW-1:0]   cx, cy;
  logic [RTW-1:0]  pt_dist;
  logic [NUMW-1:0] num, qv;
  logic [16:0]     path_pos;
  logic [NUMW:0]   s_v;
  logic [FRW-1:0]  f;
  logic [XW-1:0]   lax, lay, las;
  logic [MW-1:0]   ldx, ldy, lds;
  logic [XW-1:0]   lx, ly, ls;

  // RAM, arithmetic units
  logic                ram_we;
  logic [3*XW-1:0]     rdata;
  logic [XW-1:0]       rx, ry, rs;
  logic [MW-1:0]       mul_a, mul_b;
  logic [PW-1:0]       mul_p;
  div_req_t            div_req;
  logic                div_done, div_ovf;
  logic [QW-1:0]       quot;
  sq_req_t             sq_req;
  logic                sq_done;
  logic [RTW-1:0]      root;

  logic [CW-1:0]   n_c;
  logic [CW-1:0]   last;
  logic            is_last;
  logic [IW-1:0]   sa_c;
  logic [PW-1:0]   sq_sum;
  logic            t_zero, t_full, t_div;
  logic [56:0]     pos_n;
  logic [LENW:0]   len_sum;
  plm_out_t        res_c;
  logic            in_acc;

  assign rx = rdata[XW-1:0];
  assign ry = rdata[2*XW-1:XW];
  assign rs = rdata[3*XW-1:2*XW];

  assign in_ready  = (state == S_IDLE);
  // count writes only land while idle and no input beat is offered
  assign cfg_ready = (state == S_IDLE) & ~in_valid;
  assign in_acc    = in_valid & in_ready;
  assign ram_we    = in_acc & (in_data.req_type == REQ_LOAD)
                     & (32'(in_data.wp_index) < MAX_POINTS);

  assign n_c     = (32'(count_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_reg);
  assign last    = n - CW'(1);
  assign is_last = (CW'(i) == last);
  assign sa_c    = (CW'(best_i) == last) ? IW'(n - CW'(2)) : best_i;
  assign sq_sum  = acc + mul_p;
  assign t_zero  = (len2 == '0) || dneg || (dot == '0);
  assign t_full  = dot >= {1'b0, len2};
  assign t_div   = ~t_zero & ~t_full;
  assign pos_n   = {num, 16'b0} + 57'(end_v >> 1);
  assign len_sum = {1'b0, total_len} + (LENW+1)'(root);

  plm_ram #(.WIDTH(3*XW), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(in_data.wp_index)),
    .wdata ({in_data.wp_speed, in_data.wp_y, in_data.wp_x}),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  plm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  plm_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quot(quot), .ovf(div_ovf)
  );

  plm_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .done(sq_done), .root(root));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX:    begin mul_a = dmx;        mul_b = dmx;        end
      S_SQY:    begin mul_a = dmy;        mul_b = dmy;        end
      S_SEG_M1: begin mul_a = mag33(ex);  mul_b = mag33(ex);  end
      S_SEG_M2: begin mul_a = mag33(ey);  mul_b = mag33(ey);  end
      S_SEG_M3: begin mul_a = mag33(ex);  mul_b = mag33(px);  end
      S_SEG_M4: begin mul_a = mag33(ey);  mul_b = mag33(py);  end
      S_CX_M:   begin mul_a = mag33(ex);  mul_b = MW'(t);     end
      S_CX_R:   begin mul_a = mag33(ey);  mul_b = MW'(t);     end
      S_LX_M:   begin mul_a = mag33(ldx); mul_b = MW'(f);     end
      S_LX_R:   begin mul_a = mag33(ldy); mul_b = MW'(f);     end
      S_LY_R:   begin mul_a = mag33(lds); mul_b = MW'(f);     end
      S_LOOK0:  begin mul_a = MW'(la);    mul_b = MW'(last);  end
      default:  begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_SEG_T2: begin
        div_req.start   = t_div;
        div_req.rem0    = dot[DW-1:0];
        div_req.divisor = len2;
        div_req.steps   = T_STEPS;
      end
      S_POS: begin
        div_req.start   = 1'b1;
        div_req.dvd     = {pos_n, 39'b0};
        div_req.divisor = DW'(end_v);
        div_req.steps   = POS_STEPS;
      end
      S_LOOK1: begin
        div_req.start   = 1'b1;
        div_req.dvd     = {mul_p[40:0], 55'b0};
        div_req.divisor = DW'(total_len);
        div_req.steps   = LOOK_STEPS;
      end
      default: div_req = '0;
    endcase
  end

  assign sq_req = {(state == S_SQS) && (phase != PH_NEAR), sq_sum};

  always_comb begin
    res_c            = '0;
    res_c.status     = err ? ST_FEW : ST_OK;
    if (!err) begin
      res_c.closest_x  = cx;
      res_c.closest_y  = cy;
      res_c.path_pos   = path_pos;
      res_c.distance   = pt_dist;
      res_c.look_x     = lx;
      res_c.look_y     = ly;
      res_c.look_speed = ls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LEN;
      out_valid <= 1'b0;
      len_ok    <= 1'b0;
      count_reg <= '0;
      total_len <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            count_reg <= cfg_data;
            len_ok    <= 1'b0;
          end
          if (in_acc) begin
            if (in_data.req_type == REQ_LOAD) begin
              len_ok <= 1'b0;
            end else begin
              qx     <= in_data.query_x;
              qy     <= in_data.query_y;
              la     <= in_data.lookahead_dist;
              n      <= n_c;
              end_v  <= NUMW'(n_c - CW'(1)) << FRW;
              err    <= (n_c < CW'(2));
              i      <= '0;
              rd_idx <= '0;
              if (n_c < CW'(2)) begin
                state <= S_DONE;
              end else if (len_ok) begin
                phase <= PH_NEAR;
                state <= S_RD;
              end else begin
                phase     <= PH_LEN;
                total_len <= '0;
                state     <= S_RD;
              end
            end
          end
        end
        S_RD: state <= S_GET;
        S_GET: begin
          case (phase)
            PH_LEN: begin
              prev_x <= rx;
              prev_y <= ry;
              if (i == '0) begin
                i      <= IW'(1);
                rd_idx <= IW'(1);
                state  <= S_RD;
              end else begin
                dmx   <= mag33(diff33(rx, prev_x));
                dmy   <= mag33(diff33(ry, prev_y));
                state <= S_SQX;
              end
            end
            PH_NEAR: begin
              dmx   <= mag33(diff33(rx, qx));
              dmy   <= mag33(diff33(ry, qy));
              state <= S_SQX;
            end
            PH_SEGA: begin
              ax     <= rx;
              ay     <= ry;
              rd_idx <= sa + IW'(1);
              phase  <= PH_SEGB;
              state  <= S_RD;
            end
            PH_SEGB: begin
              ex    <= diff33(rx, ax);
              ey    <= diff33(ry, ay);
              px    <= diff33(qx, ax);
              py    <= diff33(qy, ay);
              state <= S_SEG_M1;
            end
            PH_LOOKA: begin
              lax    <= rx;
              lay    <= ry;
              las    <= rs;
              rd_idx <= rd_idx + IW'(1);
              phase  <= PH_LOOKB;
              state  <= S_RD;
            end
            PH_LOOKB: begin
              ldx   <= diff33(rx, lax);
              ldy   <= diff33(ry, lay);
              lds   <= diff33(rs, las);
              state <= S_LX_M;
            end
            PH_LAST: begin
              lx    <= rx;
              ly    <= ry;
              ls    <= rs;
              state <= S_DONE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= mul_p;
          state <= S_SQS;
        end
        S_SQS: begin
          acc   <= sq_sum;
          state <= (phase == PH_NEAR) ? S_NEAR_CMP : S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            if (phase == PH_LEN) begin
              total_len <= len_sum[LENW] ? LEN_MAX : len_sum[LENW-1:0];
              state     <= S_RD;
              if (is_last) begin
                len_ok <= 1'b1;
                phase  <= PH_NEAR;
                i      <= '0;
                rd_idx <= '0;
              end else begin
                i      <= i + IW'(1);
                rd_idx <= i + IW'(1);
              end
            end else begin
              pt_dist <= root;
              num     <= (NUMW'(sa) << FRW) + NUMW'(t);
              state   <= S_POS;
            end
          end
        end
        S_NEAR_CMP: begin
          // strict compare: the earliest waypoint wins a tie
          if (i == '0 || acc < best_d) begin
            best_d <= acc;
            best_i <= i;
          end
          if (is_last) begin
            state <= S_SEG0;
          end else begin
            i      <= i + IW'(1);
            rd_idx <= i + IW'(1);
            state  <= S_RD;
          end
        end
        S_SEG0: begin
          sa     <= sa_c;
          rd_idx <= sa_c;
          phase  <= PH_SEGA;
          state  <= S_RD;
        end
        S_SEG_M1: state <= S_SEG_M2;
        S_SEG_M2: begin
          len2  <= mul_p;
          pos   <= '0;
          neg   <= '0;
          state <= S_SEG_M3;
        end
        S_SEG_M3: begin
          len2  <= len2 + mul_p;
          state <= S_SEG_M4;
        end
        S_SEG_M4: begin
          if (ex[MW-1] ^ px[MW-1]) neg <= (PW+1)'(mul_p);
          else pos <= (PW+1)'(mul_p);
          state <= S_SEG_M5;
        end
        S_SEG_M5: begin
          if (ey[MW-1] ^ py[MW-1]) neg <= neg + (PW+1)'(mul_p);
          else pos <= pos + (PW+1)'(mul_p);
          state <= S_SEG_T;
        end
        S_SEG_T: begin
          {dneg, dot} <= {1'b0, pos} - {1'b0, neg};
          state       <= S_SEG_T2;
        end
        S_SEG_T2: begin
          if (t_zero) begin
            t     <= '0;
            state <= S_CX_M;
          end else if (t_full) begin
            t     <= ONE30;
            state <= S_CX_M;
          end else begin
            state <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          if (div_done) begin
            t     <= {1'b0, quot[FRW-1:0]};
            state <= S_CX_M;
          end
        end
        S_CX_M: state <= S_CX_R;
        S_CX_R: begin
          cx    <= lerp_fin(ax, ex, mul_p);
          state <= S_CY_R;
        end
        S_CY_R: begin
          cy    <= lerp_fin(ay, ey, mul_p);
          state <= S_DIST;
        end
        S_DIST: begin
          dmx   <= mag33(diff33(cx, qx));
          dmy   <= mag33(diff33(cy, qy));
          phase <= PH_DIST;
          state <= S_SQX;
        end
        S_POS: state <= S_DIV_P;
        S_DIV_P: begin
          if (div_done) begin
            path_pos <= quot[16:0];
            state    <= S_LOOK0;
          end
        end
        S_LOOK0: begin
          if (total_len == '0) begin
            qv    <= '0;
            state <= S_LOOK2;
          end else begin
            state <= S_LOOK1;
          end
        end
        S_LOOK1: state <= S_DIV_L;
        S_DIV_L: begin
          if (div_done) begin
            qv    <= (div_ovf || quot > QW'(end_v)) ? end_v : quot[NUMW-1:0];
            state <= S_LOOK2;
          end
        end
        S_LOOK2: begin
          s_v   <= {1'b0, num} + {1'b0, qv};
          state <= S_LOOK3;
        end
        S_LOOK3: begin
          if (s_v >= {1'b0, end_v}) begin
            rd_idx <= IW'(last);
            phase  <= PH_LAST;
          end else begin
            rd_idx <= s_v[FRW +: IW];
            f      <= s_v[FRW-1:0];
            phase  <= PH_LOOKA;
          end
          state <= S_RD;
        end
        S_LX_M: state <= S_LX_R;
        S_LX_R: begin
          lx    <= lerp_fin(lax, ldx, mul_p);
          state <= S_LY_R;
        end
        S_LY_R: begin
          ly    <= lerp_fin(lay, ldy, mul_p);
          state <= S_LS_R;
        end
        S_LS_R: begin
          ls    <= lerp_fin(las, lds, mul_p);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res_c;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/plm_checker.sv @@
// Port-level checks for polyline_closest_point_lookahead, bound to the top.
// Depends on plm_pkg.
module plm_checker import plm_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input plm_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input plm_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.req_type == REQ_QUERY |=> !in_ready)
    else $error("ready right after a query beat");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.req_type == REQ_LOAD |=> in_ready)
    else $error("load beat held the block busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FEW |->
      out_data.closest_x == 0 && out_data.closest_y == 0 && out_data.path_pos == 0 &&
      out_data.distance == 0 && out_data.look_x == 0 && out_data.look_y == 0 &&
      out_data.look_speed == 0)
    else $error("error result carries nonzero fields");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.path_pos <= 17'd65536)
    else $error("path position beyond end");

endmodule

bind polyline_closest_point_lookahead plm_checker u_plm_checker (.*);
